>>> rtl/shabsh_pkg.sv
// Shared types, round constants and mixing functions for the SHA-256 byte hasher.
// No dependencies; imported by sha256_byte_stream_hasher_core.
package shabsh_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0]  byte_type;

   localparam byte_type PAD_MARK  = 8'h80;
   localparam byte_type PAD_ZERO  = 8'h00;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam word_type H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type ror32(input word_type x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
   endfunction

endpackage

>>> rtl/sha256_byte_stream_hasher_core.sv
// SHA-256 hasher taking at most one message byte per transfer and one round per cycle.
// A byte transfer is taken in IDLE; one that completes a 64-byte block starts a compression
// (64 rounds on the shared round unit plus chaining add). An end transfer pads one
// byte per cycle (up to 64, plus a second block when needed), compresses, then
// offers 8 digest words, one per cycle while rsp_ready holds. req_ready is low meanwhile.
// Reset (synchronous, active high) restores the initial hash and clears count and fill.
module sha256_byte_stream_hasher_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  shabsh_pkg::byte_type  req_data_byte,
   input  logic                  req_byte_present,
   input  logic                  req_end_of_message,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output shabsh_pkg::word_type  rsp_digest_word,
   output logic [2:0]            rsp_word_index,
   output logic                  rsp_last_word
);
   import shabsh_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_ROUND = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   localparam logic [1:0] PH_MARK = 2'd0;
   localparam logic [1:0] PH_ZERO = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   phase_ff, phase_in;
   logic         finishing_ff, finishing_in;
   logic [5:0]   fill_ff, fill_in;
   logic [5:0]   round_ff, round_in;
   logic [2:0]   out_idx_ff, out_idx_in;
   logic [63:0]  bits_ff, bits_in;
   logic [511:0] block_ff, block_in;
   word_type     chain_ff [8];
   word_type     chain_in [8];
   word_type     v_ff [8];
   word_type     v_in [8];

   logic         push_en;
   byte_type     push_byte;
   logic         wrap;
   logic [63:0]  len_shift;
   word_type     w0, w1, w9, w14, w_new;
   word_type     t1, t2;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == 3'd7);

   assign len_shift = bits_ff << {fill_ff[2:0], 3'b000};
   assign wrap      = push_en && (fill_ff == 6'd63);

   assign w0    = block_ff[511:480];
   assign w1    = block_ff[479:448];
   assign w9    = block_ff[223:192];
   assign w14   = block_ff[63:32];
   assign w_new = w0 + small_sigma0(w1) + w9 + small_sigma1(w14);

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[round_ff] + w0;
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      push_en   = 1'b0;
      push_byte = req_data_byte;
      phase_in  = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            push_en = req_valid && req_byte_present;
         end
         ST_PAD: begin
            push_en = 1'b1;
            case (phase_ff)
               PH_MARK: begin
                  push_byte = PAD_MARK;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == LEN_START) begin
                     push_byte = len_shift[63:56];
                     phase_in  = PH_LEN;
                  end else begin
                     push_byte = PAD_ZERO;
                  end
               end
               default: begin
                  push_byte = len_shift[63:56];
               end
            endcase
         end
         default: begin
            push_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      finishing_in = finishing_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      out_idx_in   = out_idx_ff;
      bits_in      = bits_ff;
      block_in     = block_ff;
      for (int i = 0; i < 8; i++) begin
         chain_in[i] = chain_ff[i];
         v_in[i]     = v_ff[i];
      end

      if (push_en) begin
         block_in = {block_ff[503:0], push_byte};
         fill_in  = fill_ff + 6'd1;
      end
      if (wrap) begin
         round_in = 6'd0;
         for (int i = 0; i < 8; i++) begin
            v_in[i] = chain_ff[i];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_byte_present) begin
                  bits_in = bits_ff + 64'd8;
               end
               if (req_end_of_message) begin
                  finishing_in = 1'b1;
               end
               if (wrap) begin
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (wrap) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in[0]  = t1 + t2;
            v_in[1]  = v_ff[0];
            v_in[2]  = v_ff[1];
            v_in[3]  = v_ff[2];
            v_in[4]  = v_ff[3] + t1;
            v_in[5]  = v_ff[4];
            v_in[6]  = v_ff[5];
            v_in[7]  = v_ff[6];
            block_in = {block_ff[479:0], w_new};
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            if (!finishing_ff) begin
               state_in = ST_IDLE;
            end else if (phase_ff == PH_LEN) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) begin
                     chain_in[i] = H_INIT[i];
                  end
                  fill_in      = 6'd0;
                  bits_in      = 64'd0;
                  finishing_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_MARK;
         finishing_ff <= 1'b0;
         fill_ff      <= 6'd0;
         round_ff     <= 6'd0;
         out_idx_ff   <= 3'd0;
         bits_ff      <= 64'd0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= H_INIT[i];
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= (state_ff == ST_IDLE) ? PH_MARK : phase_in;
         finishing_ff <= finishing_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         bits_ff      <= bits_in;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
      for (int i = 0; i < 8; i++) begin
         v_ff[i] <= v_in[i];
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request and response sides open together");

   a_round_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 6'd63) |=> (state_ff == ST_ADD))
      else $error("compression did not end after final round");

   a_len_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && phase_ff == PH_LEN) |-> (fill_ff[5:3] == 3'b111))
      else $error("length bytes outside last eight block positions");

   a_digest_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=>
         (state_ff == ST_IDLE && fill_ff == 6'd0 && bits_ff == 64'd0
          && chain_ff[0] == H_INIT[0] && !finishing_ff))
      else $error("state not restored after digest");

   a_out_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (out_idx_ff == 3'd0 && fill_ff == 6'd0))
      else $error("digest offered mid-block or mid-sequence");

endmodule

>>> tb/tb_sha256_byte_stream_hasher_core.sv
// Self-checking testbench for sha256_byte_stream_hasher_core: directed rows, then random messages.
// Digests come from a local SHA-256 model or known constants; shabsh_pkg gives only the types.
module tb_sha256_byte_stream_hasher_core;
   import shabsh_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 600000;
   localparam int unsigned ITEM_TARGET = 360;
   localparam int unsigned TAIL_CYCLES = 150;
   localparam int unsigned MSG_LEN_BOUNDS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
   localparam byte_type LEAD_PAD = 8'h80;
   localparam int unsigned LENGTH_SLOT = 56;

   localparam word_type SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;
   localparam logic [255:0] NO_DIGEST = '0;

   typedef struct packed {
      byte_type     data;
      logic         present;
      logic         eom;
      logic         known;
      logic [255:0] digest;
   } stim_row_type;

   typedef struct {
      word_type   word;
      logic [2:0] idx;
      logic       last;
   } digest_word_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_PATTERN, RDY_COIN} ready_mode_type;

   localparam int DIR_COUNT = 20;
   localparam stim_row_type DIR_ROWS [DIR_COUNT] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h5a, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
      '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
      '{8'h80, 1'b1, 1'b1, 1'b0, NO_DIGEST},
      '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
      '{8'h3c, 1'b0, 1'b0, 1'b0, NO_DIGEST},
      '{8'hc3, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
      '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
      '{8'ha5, 1'b0, 1'b1, 1'b1, ABC_DIGEST}};

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   byte_type   req_data_byte = '0;
   logic       req_byte_present = 1'b0;
   logic       req_end_of_message = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   word_type   rsp_digest_word;
   logic [2:0] rsp_word_index;
   logic       rsp_last_word;

   word_type        hash_chain [8];
   byte_type        block_bytes [64];
   int unsigned     block_fill;
   logic [63:0]     msg_bits_total;
   word_type        fresh_digest [8];
   digest_word_type digest_q [$];

   int unsigned     fail_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     items_sent = 0;
   int unsigned     burst_left = 0;
   ready_mode_type  ready_mode = RDY_ALWAYS;
   int unsigned     ready_span = 0;
   logic [15:0]     ready_mask = '1;
   logic [3:0]      ready_phase = '0;

   sha256_byte_stream_hasher_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d digest words outstanding",
                  cycle_count, digest_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic word_type rotr(input word_type x, input int unsigned n);
      logic [63:0] both;
      both = {x, x} >> n;
      return both[31:0];
   endfunction

   function automatic void compress_block();
      word_type sched [64];
      word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                     block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
      e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[t] + sched[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
      hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
   endfunction

   function automatic void load_byte(input byte_type b);
      block_bytes[block_fill] = b;
      block_fill++;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
   endfunction

   function automatic void restart_hash();
      hash_chain = SHA_IV;
      block_fill = 0;
      msg_bits_total = '0;
   endfunction

   // Returns 1 when the item finishes a message; the digest is left in fresh_digest.
   function automatic logic absorb_item(input byte_type d, input logic p, input logic e);
      logic [63:0] len;
      if (p) begin
         msg_bits_total += 64'd8;
         load_byte(d);
      end
      if (!e)
         return 1'b0;
      len = msg_bits_total;
      load_byte(LEAD_PAD);
      while (block_fill != LENGTH_SLOT)
         load_byte(8'h00);
      for (int i = 0; i < 8; i++)
         load_byte(len[63 - 8*i -: 8]);
      fresh_digest = hash_chain;
      restart_hash();
      return 1'b1;
   endfunction

   task automatic send_item(input byte_type d, input logic p, input logic e,
                            input logic known, input logic [255:0] known_digest);
      digest_word_type dw;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 80)
                                                : $urandom_range(1, 20);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= d;
      req_byte_present   <= p;
      req_end_of_message <= e;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
      if (absorb_item(d, p, e)) begin
         for (int i = 0; i < 8; i++) begin
            dw.word = known ? known_digest[255 - 32*i -: 32] : fresh_digest[i];
            dw.idx  = 3'(i);
            dw.last = (i == 7);
            digest_q.push_back(dw);
         end
      end
   endtask

   task automatic drain_digests();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (digest_q.size() != 0);
   endtask

   task automatic send_message(input int unsigned len, input logic end_on_byte);
      for (int unsigned k = 0; k < len; k++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(byte_type'($urandom), 1'b0, 1'b0, 1'b0, NO_DIGEST);
         send_item(byte_type'($urandom), 1'b1, end_on_byte && (k == len - 1), 1'b0,
                   NO_DIGEST);
      end
      if (!end_on_byte || len == 0)
         send_item(byte_type'($urandom), 1'b0, 1'b1, 1'b0, NO_DIGEST);
   endtask

   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_span = $urandom_range(16, 160);
         ready_mask = 16'($urandom) | 16'h0001;
      end
      ready_span--;
      ready_phase++;
      case (ready_mode)
         RDY_ALWAYS:  rsp_ready <= 1'b1;
         RDY_MOSTLY:  rsp_ready <= ($urandom_range(0, 3) != 0);
         RDY_PATTERN: rsp_ready <= ready_mask[ready_phase];
         default:     rsp_ready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   always @(posedge clock) begin : rsp_check
      digest_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected digest word %h idx %0d last %b",
                        rsp_digest_word, rsp_word_index, rsp_last_word);
         end else begin
            want = digest_q.pop_front();
            if (rsp_digest_word !== want.word || rsp_word_index !== want.idx ||
                rsp_last_word !== want.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                           want.word, want.idx, want.last,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
            end
         end
      end
   end

   initial begin
      int unsigned msg_count;
      int unsigned len;
      logic        end_on_byte;
      restart_hash();
      msg_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_COUNT; r++)
         send_item(DIR_ROWS[r].data, DIR_ROWS[r].present, DIR_ROWS[r].eom,
                   DIR_ROWS[r].known, DIR_ROWS[r].digest);
      drain_digests();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 7)
            len = $urandom_range(0, 20);
         else
            len = MSG_LEN_BOUNDS[$urandom_range(0, 7)];
         if (len > ITEM_TARGET - items_sent)
            len = ITEM_TARGET - items_sent;
         end_on_byte = 1'($urandom_range(0, 1));
         send_message(len, end_on_byte);
         msg_count++;
         if (msg_count == 4)
            drain_digests();
      end

      req_valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
